[design/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define A85_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define A85_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[design/a85_pkg.sv]
// types and constants of the ascii85 encoder
package a85_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } a85_in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       out_last;
  } a85_out_t;

  typedef struct packed {
    logic       open_delim;
    logic       conv;
    logic       zero_grp;
    logic [2:0] ndig;
    logic       close_delim;
    logic       last;
  } a85_ctrl_t;

  typedef struct packed {
    logic [31:0]     v;
    logic [3:0][6:0] rem;
    a85_ctrl_t       ctrl;
  } a85_stage_t;

  localparam logic [31:0] A85Base     = 32'd85;
  localparam logic [31:0] A85DivMagic = 32'hC0C0C0C1;
  localparam int unsigned A85DivShift = 38;
  localparam logic [6:0]  A85Offset   = 7'd33;

  localparam logic [6:0]  A85ChZero   = 7'h7A;
  localparam logic [6:0]  A85ChLt     = 7'h3C;
  localparam logic [6:0]  A85ChTilde  = 7'h7E;
  localparam logic [6:0]  A85ChGt     = 7'h3E;

  localparam logic        A85RegAddDelim = 1'b0;

endpackage

[design/a85_div_stage.sv]
// one pipeline stage that splits off the low base-85 digit
module a85_div_stage
  import a85_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  a85_stage_t in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output a85_stage_t out_data_o
);

  logic       valid_q;
  a85_stage_t data_q;
  a85_stage_t data_d;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] diff;

  // quotient by reciprocal multiply, exact for any 32-bit value
  always_comb begin
    prod = 64'(in_data_i.v) * 64'(A85DivMagic);
    quot = {{(64 - 32 - (64 - A85DivShift)){1'b0}}, prod[63:A85DivShift]};
    diff = in_data_i.v - quot * A85Base;
    data_d      = in_data_i;
    data_d.v    = quot;
    data_d.rem  = {diff[6:0], in_data_i.rem[3:1]};
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

[design/a85_emitter.sv]
// steps through the characters of one converted request, one per cycle while the output is not stalled
module a85_emitter
  import a85_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  output logic       job_ready_o,
  input  a85_stage_t job_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output a85_out_t   out_data_o
);

  logic       job_valid_q;
  a85_stage_t job_q;
  logic [3:0] idx_q;
  logic       out_valid_q;
  a85_out_t   out_q;

  logic [3:0] open_cnt;
  logic [3:0] body_cnt;
  logic [3:0] close_cnt;
  logic [3:0] total;
  logic [3:0] j;
  logic [3:0] k;
  logic [6:0] digit;
  logic [6:0] ch;
  logic       last_char;
  logic       out_free;
  logic       emit;

  always_comb begin
    open_cnt  = job_q.ctrl.open_delim ? 4'd2 : 4'd0;
    close_cnt = job_q.ctrl.close_delim ? 4'd2 : 4'd0;
    if (!job_q.ctrl.conv) begin
      body_cnt = 4'd0;
    end else if (job_q.ctrl.zero_grp) begin
      body_cnt = 4'd1;
    end else begin
      body_cnt = {1'b0, job_q.ctrl.ndig};
    end
    total     = open_cnt + body_cnt + close_cnt;
    last_char = (idx_q == total - 4'd1);
    j         = idx_q - open_cnt;
    k         = j - body_cnt;

    // most significant digit is the final quotient
    case (j)
      4'd0:    digit = job_q.v[6:0];
      4'd1:    digit = job_q.rem[3];
      4'd2:    digit = job_q.rem[2];
      4'd3:    digit = job_q.rem[1];
      default: digit = job_q.rem[0];
    endcase

    if (idx_q < open_cnt) begin
      ch = (idx_q == 4'd0) ? A85ChLt : A85ChTilde;
    end else if (j < body_cnt) begin
      ch = job_q.ctrl.zero_grp ? A85ChZero : digit + A85Offset;
    end else begin
      ch = (k == 4'd0) ? A85ChTilde : A85ChGt;
    end
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign emit        = job_valid_q && out_free;
  assign job_ready_o = !job_valid_q || (emit && last_char);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_ready_o) begin
        job_valid_q <= job_valid_i;
        idx_q       <= 4'd0;
      end else if (emit) begin
        idx_q <= idx_q + 4'd1;
      end
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_ready_o && job_valid_i) begin
      job_q <= job_data_i;
    end
    if (emit) begin
      out_q.out_char <= ch;
      out_q.out_last <= job_q.ctrl.last && last_char;
    end
  end

endmodule

[design/ascii85_encoder.sv]
// ascii85 encoder top level: group gathering, base-85 pipeline and character output
// a request is taken every cycle while the pipeline has room; after acceptance its
// first character passes the input register, four divide stages, the character
// sequencer and the output register; characters leave at one per cycle while the
// output is not stalled, and a request makes from 0 to 7 characters
// reset (asynchronous) empties the pipeline, clears the open group and sets add_delimiters
module ascii85_encoder
  import a85_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  a85_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output a85_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        add_delim_q;
  logic [23:0] group_q;
  logic [1:0]  count_q;
  logic        started_q;

  logic        s0_valid_q;
  a85_stage_t  s0_q;
  a85_stage_t  s0_d;
  logic        s0_emits;
  logic        accept;
  logic        cfg_wr;

  a85_stage_t  stg       [0:4];
  logic [4:0]  stg_valid;
  logic [4:0]  stg_ready;

  logic [31:0] word;
  logic        held4;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == A85RegAddDelim);
  assign prdata = (paddr[2] == A85RegAddDelim) ? {31'd0, add_delim_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_delim_q <= 1'b1;
    end else if (cfg_wr) begin
      add_delim_q <= pwdata[0];
    end
  end

  // group gathering, left-aligned with zero padding
  always_comb begin
    held4 = (count_q == 2'd3);
    case (count_q)
      2'd0:    word = {in_data_i.data_byte, 24'd0};
      2'd1:    word = {group_q[7:0], in_data_i.data_byte, 16'd0};
      2'd2:    word = {group_q[15:0], in_data_i.data_byte, 8'd0};
      default: word = {group_q, in_data_i.data_byte};
    endcase
    s0_d                  = '0;
    s0_d.v                = word;
    s0_d.ctrl.open_delim  = !started_q && add_delim_q;
    s0_d.ctrl.conv        = held4 || in_data_i.last_byte;
    s0_d.ctrl.zero_grp    = held4 && (word == 32'd0);
    s0_d.ctrl.ndig        = {1'b0, count_q} + 3'd2;
    s0_d.ctrl.close_delim = in_data_i.last_byte && add_delim_q;
    s0_d.ctrl.last        = in_data_i.last_byte;
    s0_emits              = s0_d.ctrl.open_delim || s0_d.ctrl.conv;
  end

  assign in_ready_o = !s0_valid_q || stg_ready[0];
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q    <= 24'd0;
      count_q    <= 2'd0;
      started_q  <= 1'b0;
      s0_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s0_valid_q <= accept && s0_emits;
      end
      if (accept) begin
        started_q <= !in_data_i.last_byte;
        if (s0_d.ctrl.conv) begin
          group_q <= 24'd0;
          count_q <= 2'd0;
        end else begin
          group_q <= {group_q[15:0], in_data_i.data_byte};
          count_q <= count_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_q <= s0_d;
    end
  end

  assign stg[0]       = s0_q;
  assign stg_valid[0] = s0_valid_q;

  for (genvar g = 1; g <= 4; g++) begin : g_div
    a85_div_stage u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stg_valid[g-1]),
      .in_ready_o  (stg_ready[g-1]),
      .in_data_i   (stg[g-1]),
      .out_valid_o (stg_valid[g]),
      .out_ready_i (stg_ready[g]),
      .out_data_o  (stg[g])
    );
  end

  a85_emitter u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (stg_valid[4]),
    .job_ready_o (stg_ready[4]),
    .job_data_i  (stg[4]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[design/a85_checker.sv]
// port-level checks for the ascii85 encoder and their bind
`include "assert_macros.svh"

module a85_checker
  import a85_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input a85_in_t     in_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input a85_out_t    out_data_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == A85RegAddDelim);

  // a waiting request holds
  `A85_ASSERT(a_in_hold, (in_valid_i && !in_ready_o) |=> (in_valid_i && $stable(in_data_i)), "request changed while waiting")

  // a stalled character holds
  `A85_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)), "output changed while stalled")

  // written delimiter flag reads back
  `A85_ASSERT(a_cfg_readback, cfg_wr |=> (paddr[2] != A85RegAddDelim || prdata[0] == $past(pwdata[0])), "add_delimiters readback mismatch")

  // every character is printable ascii85 output
  `A85_ASSERT(a_char_range, out_valid_o |-> (out_data_o.out_char >= 7'd33 && out_data_o.out_char <= 7'd126), "character out of range")

  // no output while in reset
  `A85_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind ascii85_encoder a85_checker u_a85_checker (.*);
